@@ rtl/core/pgb_pkg.sv @@
package pgb_pkg;

    // Request kinds carried in req_type.
    localparam logic [1:0] REQ_LOAD_PIXEL = 2'd0;
    localparam logic [1:0] REQ_LOAD_WIDTH = 2'd1;
    localparam logic [1:0] REQ_SET_PEN    = 2'd2;
    localparam logic [1:0] REQ_DRAW       = 2'd3;

    // Character codes with a fixed meaning.
    localparam logic [7:0] CODE_FIRST = 8'h20;
    localparam logic [7:0] CODE_FONT0 = 8'h7B;
    localparam logic [7:0] CODE_FONT1 = 8'h7D;
    localparam logic [7:0] CODE_FONT2 = 8'h5B;

    // Configuration register indexes, selected by paddr[2].
    localparam logic REG_GLYPH_WIDTH  = 1'b0;
    localparam logic REG_GLYPH_HEIGHT = 1'b1;

    localparam logic [4:0] GLYPH_DIM = 5'd16;

    // Side information that travels with one font memory read.
    typedef struct packed {
        logic half;
        logic last;
    } t_row_tag;

    // Glyph width and height settings above 16 behave as 16.
    function automatic logic [4:0] clamp16(input logic [4:0] v);
        clamp16 = (v > GLYPH_DIM) ? GLYPH_DIM : v;
    endfunction

endpackage

@@ rtl/core/proportional_glyph_blitter_top.sv @@
// Load, font select and ignored requests complete in the idle state; set pen also
// passes through the pen state. A drawn character reads two 8-byte font words per
// glyph row, one word per cycle while output is not stalled, then advances the pen;
// no rows are read at height zero. Each word passes stage one, then the output register.
// Reset clears pen, font select and handshake state and sets both glyph sizes to 16;
// the font memory and width table are not cleared and hold nothing until loaded.
module proportional_glyph_blitter_top #(
    parameter int SCREEN_WIDTH  = 640,
    parameter int SCREEN_HEIGHT = 480,
    parameter int GLYPH_COUNT   = 96,
    parameter int FONT_COUNT    = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [1:0]  i_font_index,
    input  logic [7:0]  i_char_code,
    input  logic [3:0]  i_glyph_row,
    input  logic [3:0]  i_glyph_col,
    input  logic [7:0]  i_load_value,
    input  logic [9:0]  i_pen_x,
    input  logic [8:0]  i_pen_y,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [18:0] o_write_address,
    output logic [63:0] o_pixel_bytes,
    output logic [7:0]  o_write_mask,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pgb_pkg::*;

    localparam int FRAME_SIZE = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int PEN_W      = $clog2(FRAME_SIZE + 1);
    localparam int ADDR_W     = $clog2(FRAME_SIZE + 16 * SCREEN_WIDTH);
    localparam int SP_W       = $clog2(511 * SCREEN_WIDTH + 1024);
    localparam int SAT_W      = (SP_W > PEN_W) ? SP_W : PEN_W;
    localparam int GLYPHS     = FONT_COUNT * GLYPH_COUNT;
    localparam int GI_W       = (GLYPHS > 1) ? $clog2(GLYPHS) : 1;
    localparam int WA_W       = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
    localparam int FA_W       = GI_W + 5;
    localparam int FSEL1      = (FONT_COUNT > 1) ? 1 : FONT_COUNT - 1;
    localparam int FSEL2      = (FONT_COUNT > 2) ? 2 : FONT_COUNT - 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PEN  = 2'd1;
    localparam logic [1:0] ST_DRAW = 2'd2;
    localparam logic [1:0] ST_ADV  = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [PEN_W-1:0]  r_pen, n_pen;
    logic [1:0]        r_font_sel, n_font_sel;
    logic [4:0]        r_glyph_width;
    logic [4:0]        r_glyph_height;
    logic [3:0]        r_dy, n_dy;
    logic              r_half, n_half;
    logic [ADDR_W-1:0] r_row_addr, n_row_addr;
    logic [GI_W-1:0]   r_gidx;
    logic [SP_W-1:0]   r_pen_raw;

    logic              w_in_acc;
    logic              w_drawable;
    logic [7:0]        w_glyph;
    logic [GI_W-1:0]   w_load_gidx;
    logic [GI_W-1:0]   w_draw_gidx;
    logic              w_is_draw;
    logic              w_is_select;
    logic              w_start_draw;
    logic [4:0]        w_w_cl;
    logic [4:0]        w_h_cl;
    logic              w_can_issue;
    logic              w_issue;
    logic              w_last;
    logic [PEN_W:0]    w_pen_sum;
    logic [7:0]        w_adv;
    logic              w_font_wr;
    logic              w_width_wr;
    logic [63:0]       w_rd_data;
    logic [ADDR_W-1:0] w_issue_addr;
    t_row_tag          w_tag;
    logic              w_cfg_wr;

    // Request decode.
    assign w_in_acc     = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall   = (r_state != ST_IDLE);
    assign w_glyph      = i_char_code - CODE_FIRST;
    assign w_drawable   = (i_char_code >= CODE_FIRST) && (w_glyph < 8'(GLYPH_COUNT));
    assign w_load_gidx  = GI_W'(i_font_index) * GI_W'(GLYPH_COUNT) + GI_W'(w_glyph);
    assign w_draw_gidx  = GI_W'(r_font_sel) * GI_W'(GLYPH_COUNT) + GI_W'(w_glyph);
    assign w_is_draw    = w_in_acc && (i_req_type == REQ_DRAW);
    assign w_is_select  = (i_char_code == CODE_FONT0) || (i_char_code == CODE_FONT1) ||
                          (i_char_code == CODE_FONT2);
    assign w_start_draw = w_is_draw && !w_is_select && w_drawable;
    assign w_font_wr    = w_in_acc && (i_req_type == REQ_LOAD_PIXEL) && w_drawable &&
                          ({1'b0, i_font_index} < 3'(FONT_COUNT));
    assign w_width_wr   = w_in_acc && (i_req_type == REQ_LOAD_WIDTH) && w_drawable;

    assign w_w_cl = clamp16(r_glyph_width);
    assign w_h_cl = clamp16(r_glyph_height);

    // Row sequencer: one font word read per cycle while the output path has room.
    assign w_issue      = (r_state == ST_DRAW) && (w_h_cl != 5'd0) && w_can_issue;
    assign w_last       = r_half && (({1'b0, r_dy} + 5'd1) == w_h_cl);
    assign w_issue_addr = r_row_addr + (r_half ? ADDR_W'(8) : ADDR_W'(0));
    assign w_tag.half   = r_half;
    assign w_tag.last   = w_last;
    assign w_pen_sum    = (PEN_W + 1)'(r_pen) + (PEN_W + 1)'(w_adv);

    always_comb begin
        n_state    = r_state;
        n_pen      = r_pen;
        n_font_sel = r_font_sel;
        n_dy       = r_dy;
        n_half     = r_half;
        n_row_addr = r_row_addr;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (i_req_type == REQ_SET_PEN)) begin
                    n_font_sel = 2'd0;
                    n_state    = ST_PEN;
                end else if (w_is_draw && (i_char_code == CODE_FONT0)) begin
                    n_font_sel = 2'd0;
                end else if (w_is_draw && (i_char_code == CODE_FONT1)) begin
                    n_font_sel = 2'(FSEL1);
                end else if (w_is_draw && (i_char_code == CODE_FONT2)) begin
                    n_font_sel = 2'(FSEL2);
                end else if (w_start_draw) begin
                    n_dy       = 4'd0;
                    n_half     = 1'b0;
                    n_row_addr = ADDR_W'(r_pen);
                    n_state    = ST_DRAW;
                end
            end
            ST_PEN: begin
                if (SAT_W'(r_pen_raw) > SAT_W'(FRAME_SIZE)) begin
                    n_pen = PEN_W'(FRAME_SIZE);
                end else begin
                    n_pen = PEN_W'(r_pen_raw);
                end
                n_state = ST_IDLE;
            end
            ST_DRAW: begin
                if (w_h_cl == 5'd0) begin
                    n_state = ST_ADV;
                end else if (w_issue) begin
                    n_half = !r_half;
                    if (r_half) begin
                        n_dy       = r_dy + 4'd1;
                        n_row_addr = r_row_addr + ADDR_W'(SCREEN_WIDTH);
                    end
                    if (w_last) begin
                        n_state = ST_ADV;
                    end
                end
            end
            ST_ADV: begin
                if (w_pen_sum > (PEN_W + 1)'(FRAME_SIZE)) begin
                    n_pen = PEN_W'(FRAME_SIZE);
                end else begin
                    n_pen = PEN_W'(w_pen_sum);
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Configuration writes.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_GLYPH_HEIGHT) ? {27'd0, r_glyph_height} :
                                                       {27'd0, r_glyph_width};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_pen          <= '0;
            r_font_sel     <= 2'd0;
            r_dy           <= 4'd0;
            r_half         <= 1'b0;
            r_glyph_width  <= GLYPH_DIM;
            r_glyph_height <= GLYPH_DIM;
        end else begin
            r_state    <= n_state;
            r_pen      <= n_pen;
            r_font_sel <= n_font_sel;
            r_dy       <= n_dy;
            r_half     <= n_half;
            if (w_cfg_wr && (paddr[2] == REG_GLYPH_WIDTH)) begin
                r_glyph_width <= pwdata[4:0];
            end
            if (w_cfg_wr && (paddr[2] == REG_GLYPH_HEIGHT)) begin
                r_glyph_height <= pwdata[4:0];
            end
        end
    end

    // Payload registers of the current request.
    always_ff @(posedge i_clk) begin
        r_row_addr <= n_row_addr;
        if (w_in_acc && (i_req_type == REQ_SET_PEN)) begin
            r_pen_raw <= SP_W'(i_pen_y) * SP_W'(SCREEN_WIDTH) + SP_W'(i_pen_x);
        end
        if (w_start_draw) begin
            r_gidx <= w_draw_gidx;
        end
    end

    pgb_font_mem #(
        .DEPTH (GLYPHS * 32),
        .AW    (FA_W)
    ) u_font_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_font_wr),
        .i_wr_addr ({w_load_gidx, i_glyph_row, i_glyph_col[3]}),
        .i_wr_lane (i_glyph_col[2:0]),
        .i_wr_data (i_load_value),
        .i_rd_en   (w_issue),
        .i_rd_addr ({r_gidx, r_dy, r_half}),
        .o_rd_data (w_rd_data)
    );

    pgb_width_mem #(
        .DEPTH (GLYPH_COUNT),
        .AW    (WA_W)
    ) u_width_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_width_wr),
        .i_wr_addr (WA_W'(w_glyph)),
        .i_wr_data (i_load_value),
        .i_rd_en   (w_start_draw),
        .i_rd_addr (WA_W'(w_glyph)),
        .o_rd_data (w_adv)
    );

    pgb_out_stage #(
        .ADDR_W     (ADDR_W),
        .FRAME_SIZE (FRAME_SIZE)
    ) u_out_stage (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_issue         (w_issue),
        .i_addr          (w_issue_addr),
        .i_tag           (w_tag),
        .i_rd_data       (w_rd_data),
        .i_width         (w_w_cl),
        .o_can_issue     (w_can_issue),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_write_address (o_write_address),
        .o_pixel_bytes   (o_pixel_bytes),
        .o_write_mask    (o_write_mask),
        .o_last          (o_last)
    );

`ifndef SYNTH
    // The pen never leaves the frame.
    a_pen_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pen <= PEN_W'(FRAME_SIZE))
        else $error("pen beyond frame size");

    // A font load never collides with a row read.
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_font_wr && w_issue))
        else $error("font write during row read");

    // The row counter stays inside the glyph height while drawing.
    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAW) && (w_h_cl != 5'd0) |-> ({1'b0, r_dy} < w_h_cl))
        else $error("row counter past glyph height");

    // The final read of a character is followed by the pen advance.
    a_last_then_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue && w_last |=> (r_state == ST_ADV))
        else $error("no pen advance after final row");
`endif

endmodule

@@ rtl/core/pgb_font_mem.sv @@
module pgb_font_mem #(
    parameter int DEPTH = 9216,
    parameter int AW    = 14
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [2:0]    i_wr_lane,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [63:0]   o_rd_data
);

    // Eight pixel bytes per word, written one byte lane at a time.
    logic [63:0] r_mem [DEPTH];
    logic [63:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr][{i_wr_lane, 3'b000} +: 8] <= i_wr_data;
        end
    end

    // Read data is registered and holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/pgb_width_mem.sv @@
module pgb_width_mem #(
    parameter int DEPTH = 96,
    parameter int AW    = 7
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    // Advance width table shared by all fonts.
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/pgb_out_stage.sv @@
module pgb_out_stage #(
    parameter int ADDR_W     = 20,
    parameter int FRAME_SIZE = 307200
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_issue,
    input  logic [ADDR_W-1:0]   i_addr,
    input  pgb_pkg::t_row_tag   i_tag,
    input  logic [63:0]         i_rd_data,
    input  logic [4:0]          i_width,
    output logic                o_can_issue,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [18:0]         o_write_address,
    output logic [63:0]         o_pixel_bytes,
    output logic [7:0]          o_write_mask,
    output logic                o_last
);
    import pgb_pkg::*;

    // Stage one waits on the memory read data; stage two is the output register.
    logic              r_s1_v;
    logic [ADDR_W-1:0] r_s1_addr;
    t_row_tag          r_s1_tag;
    logic              r_s2_v;
    logic [18:0]       r_s2_addr;
    logic [63:0]       r_s2_bytes;
    logic [7:0]        r_s2_mask;
    logic              r_s2_last;

    logic              w_s2_free;
    logic              w_s1_move;
    logic [ADDR_W-1:0] w_room_full;
    logic [3:0]        w_room;
    logic [7:0]        w_mask;
    logic [63:0]       w_bytes;
    logic [7:0]        w_pix;

    assign w_s2_free   = !r_s2_v || !i_out_stall;
    assign w_s1_move   = r_s1_v && w_s2_free;
    assign o_can_issue = !r_s1_v || w_s2_free;

    // Number of the eight pixels that still lie inside the frame.
    always_comb begin
        w_room_full = ADDR_W'(FRAME_SIZE) - r_s1_addr;
        if (r_s1_addr >= ADDR_W'(FRAME_SIZE)) begin
            w_room = 4'd0;
        end else if (w_room_full >= ADDR_W'(8)) begin
            w_room = 4'd8;
        end else begin
            w_room = 4'(w_room_full);
        end
    end

    // A pixel is written when inside the glyph width, nonzero and inside the frame.
    always_comb begin
        w_mask  = '0;
        w_bytes = '0;
        for (int i = 0; i < 8; i++) begin
            w_pix = i_rd_data[8*i +: 8];
            if (({1'b0, r_s1_tag.half, 3'(i)} < i_width) && (w_pix != 8'd0) &&
                (4'(i) < w_room)) begin
                w_mask[i]       = 1'b1;
                w_bytes[8*i +: 8] = w_pix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (i_issue) begin
                r_s1_v <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_v <= 1'b0;
            end
            if (w_s1_move) begin
                r_s2_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_s2_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_issue) begin
            r_s1_addr <= i_addr;
            r_s1_tag  <= i_tag;
        end
        if (w_s1_move) begin
            r_s2_addr  <= 19'(r_s1_addr);
            r_s2_bytes <= w_bytes;
            r_s2_mask  <= w_mask;
            r_s2_last  <= r_s1_tag.last;
        end
    end

    assign o_out_valid     = r_s2_v;
    assign o_write_address = r_s2_addr;
    assign o_pixel_bytes   = r_s2_bytes;
    assign o_write_mask    = r_s2_mask;
    assign o_last          = r_s2_last;

endmodule
